// ----- hdl/shpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-bit header packing codec package
// Shared word types, the group job format and the codes used by the codec.
// ----------------------------------------------------------------------------
package shpc_pkg;

    localparam int GROUP_MAX = 7;
    localparam int CNT_W     = 3;

    // Direction codes.
    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

    localparam logic [7:0] LOW7_MASK = 8'h7f;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
    } result_t;

    typedef logic [GROUP_MAX-1:0][7:0] group_t;

    // One complete group, handed from the front end to the back end.
    typedef struct packed {
        logic             dir;
        logic             last;
        logic [CNT_W-1:0] count;
        logic [7:0]       header;
        group_t           bytes;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- hdl/shpc_front.sv -----
// ----------------------------------------------------------------------------
// Codec front end
// Accepts input words, builds the current group and hands each finished
// group to the job queue.
// ----------------------------------------------------------------------------
module shpc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                item_valid,
    output logic                item_stall,
    input  shpc_pkg::item_t     item,
    input  shpc_pkg::q_status_t q_status,
    output logic                job_push,
    output shpc_pkg::job_t      job
);

    logic                       dir_reg, dir_next;
    logic [shpc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]                 header_reg, header_next;
    logic                       hdr_expected_reg, hdr_expected_next;
    shpc_pkg::group_t           bytes_reg, bytes_next;

    logic                       accept;
    logic [shpc_pkg::CNT_W-1:0] count_inc;
    logic                       flush;
    logic [7:0]                 hdr_enc;
    shpc_pkg::group_t           bytes_wr;

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;
    assign count_inc  = count_reg + 1'b1;
    assign flush      = (count_inc == shpc_pkg::CNT_W'(shpc_pkg::GROUP_MAX))
                        || item.stream_last;
    // The header shifts right and picks up bit 7 of the new byte at bit 6.
    assign hdr_enc    = {1'b0, header_reg[7] | item.data_byte[7], header_reg[6:1]};

    always_comb
    begin
        bytes_wr            = bytes_reg;
        bytes_wr[count_reg] = item.data_byte;
    end

    always_comb
    begin
        dir_next          = dir_reg;
        count_next        = count_reg;
        header_next       = header_reg;
        hdr_expected_next = hdr_expected_reg;
        bytes_next        = bytes_reg;
        job_push          = 1'b0;
        job.dir           = dir_reg;
        job.last          = item.stream_last;
        job.count         = count_inc;
        job.header        = header_reg;
        job.bytes         = bytes_wr;

        if (accept)
        begin
            if (dir_reg == shpc_pkg::DIR_PACK)
            begin
                bytes_next = bytes_wr;
                job.header = hdr_enc;
                if (flush)
                begin
                    job_push          = 1'b1;
                    count_next        = '0;
                    header_next       = '0;
                    hdr_expected_next = 1'b1;
                end
                else
                begin
                    count_next  = count_inc;
                    header_next = hdr_enc;
                end
            end
            else if (hdr_expected_reg)
            begin
                // A header that ends the stream is dropped with no output.
                count_next        = '0;
                header_next       = item.stream_last ? 8'h00 : item.data_byte;
                hdr_expected_next = item.stream_last;
            end
            else
            begin
                bytes_next = bytes_wr;
                if (flush)
                begin
                    job_push          = 1'b1;
                    count_next        = '0;
                    header_next       = '0;
                    hdr_expected_next = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end

        if (cfg_wr_en)
        begin
            dir_next          = cfg_wr_data;
            count_next        = '0;
            header_next       = '0;
            hdr_expected_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg          <= shpc_pkg::DIR_PACK;
            count_reg        <= '0;
            header_reg       <= '0;
            hdr_expected_reg <= 1'b1;
        end
        else
        begin
            dir_reg          <= dir_next;
            count_reg        <= count_next;
            header_reg       <= header_next;
            hdr_expected_reg <= hdr_expected_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

// ----- hdl/shpc_queue.sv -----
// ----------------------------------------------------------------------------
// Codec job queue
// Short first-in first-out queue of finished groups between the two ends.
// ----------------------------------------------------------------------------
module shpc_queue #(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  shpc_pkg::job_t      push_job,
    input  logic                pop,
    output shpc_pkg::job_t      head,
    output shpc_pkg::q_status_t status
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    shpc_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == FILL_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/shpc_back.sv -----
// ----------------------------------------------------------------------------
// Codec back end
// Walks the group at the head of the queue and emits one word per cycle
// into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module shpc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  shpc_pkg::job_t      head,
    input  shpc_pkg::q_status_t q_status,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output shpc_pkg::result_t   result
);

    logic [shpc_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    shpc_pkg::result_t          result_reg, result_next;

    logic                       out_free;
    logic                       fire;
    logic                       at_end;
    logic [shpc_pkg::CNT_W-1:0] last_idx;
    logic [shpc_pkg::CNT_W-1:0] sel;
    logic [shpc_pkg::CNT_W-1:0] bit_pos;
    logic [7:0]                 sel_byte;
    logic [7:0]                 elem;

    assign out_free = !valid_reg || !result_stall;
    assign fire     = !q_status.empty && out_free;
    // A packed group has the header in front of its data bytes.
    assign last_idx = (head.dir == shpc_pkg::DIR_PACK) ? head.count : head.count - 1'b1;
    assign at_end   = (idx_reg == last_idx);
    assign pop      = fire && at_end;
    assign sel      = (head.dir == shpc_pkg::DIR_PACK) ? idx_reg - 1'b1 : idx_reg;
    assign sel_byte = head.bytes[sel];
    // Byte k of an n-byte group owns header bit 7-n+k.
    assign bit_pos  = shpc_pkg::CNT_W'(3'd7 - head.count + idx_reg);

    always_comb
    begin
        if (head.dir == shpc_pkg::DIR_PACK)
        begin
            if (idx_reg == '0)
            begin
                elem = head.header & shpc_pkg::LOW7_MASK;
            end
            else
            begin
                elem = sel_byte & shpc_pkg::LOW7_MASK;
            end
        end
        else
        begin
            elem = {sel_byte[7] | head.header[bit_pos], sel_byte[6:0]};
        end
    end

    always_comb
    begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        if (fire)
        begin
            valid_next             = 1'b1;
            result_next.out_byte   = elem;
            result_next.run_end    = at_end;
            result_next.stream_end = at_end && head.last;
            idx_next               = at_end ? '0 : idx_reg + 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ----- hdl/seven_bit_header_packing_codec.sv -----
// ----------------------------------------------------------------------------
// Seven-bit header packing codec
// Packs bytes into a header plus seven-bit data bytes, or unpacks them again.
// ----------------------------------------------------------------------------
//  Channel  Signals                             Word
//  item     item_valid / item_stall / item      data_byte, stream_last
//  result   result_valid / result_stall/result  out_byte, run_end, stream_end
//  config   cfg_wr_en / cfg_wr_data             direction
//
//  An input word is taken every cycle unless the group queue is full.
//  Output words leave at one per cycle while result_stall is low; a packed
//  group of n bytes gives n+1 words, so the output port sets the sustained rate.
//  With the back end idle, a group whose closing byte is taken passes through
//  the queue entry and then the output register before its first word is presented.
//  Reset clears all control state at once; no clearing pass is needed.
//  A stalled output holds its word while the front end keeps filling groups until the queue is full.
// ----------------------------------------------------------------------------
module seven_bit_header_packing_codec #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  shpc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output shpc_pkg::result_t result
);

    shpc_pkg::q_status_t q_status;
    shpc_pkg::job_t      push_job;
    shpc_pkg::job_t      head_job;
    logic                job_push;
    logic                job_pop;

    shpc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .q_status    (q_status),
        .job_push    (job_push),
        .job         (push_job)
    );

    shpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head     (head_job),
        .status   (q_status)
    );

    shpc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_job),
        .q_status     (q_status),
        .pop          (job_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- hdl/shpc_checker.sv -----
// ----------------------------------------------------------------------------
// Codec port checker
// Watches the codec ports for ordering and flow rules of the result stream.
// ----------------------------------------------------------------------------
module shpc_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input shpc_pkg::result_t result
);

    // A stalled word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // The input side only stalls while the output is busy with queued groups.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

    // A run is emitted without gaps once its first word is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.run_end |=> result_valid)
        else $error("gap inside a run of result words");

    // The end of the stream is always the end of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stream_end |-> result.run_end)
        else $error("stream end without run end");

endmodule

bind seven_bit_header_packing_codec shpc_checker u_shpc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-bit header packing codec testbench
// Sends byte streams through the codec in both directions. Random idle and
// stall cycles are applied on both channels. Every output word is checked
// against a local model of the packing and unpacking rules.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int IDLE_PERCENT  = 21;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic              cfg_wr_data  = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    shpc_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    shpc_pkg::result_t result;

    shpc_pkg::item_t   pending_bytes[$];
    shpc_pkg::result_t expected_words[$];
    shpc_pkg::result_t next_word;
    int                errors      = 0;
    int                cycle_count = 0;
    bit                calm        = 1'b0;

    // Local copy of the codec state.
    logic       mdl_dir        = shpc_pkg::DIR_PACK;
    logic [7:0] mdl_group [shpc_pkg::GROUP_MAX];
    int         mdl_count      = 0;
    logic [7:0] mdl_header     = '0;
    bit         mdl_header_due = 1'b1;

    seven_bit_header_packing_codec u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    task automatic clear_model_group();
        mdl_count      = 0;
        mdl_header     = '0;
        mdl_header_due = 1'b1;
    endtask

    // Works out the output words caused by one accepted input word.
    task automatic predict_codec_words(input shpc_pkg::item_t it);
        shpc_pkg::result_t words [shpc_pkg::GROUP_MAX+1];
        int                n;
        int                k;
        int                bitpos;
        logic [7:0]        b;
        n = 0;
        b = it.data_byte;
        if (mdl_dir == shpc_pkg::DIR_PACK)
        begin
            if (mdl_count < shpc_pkg::GROUP_MAX)
            begin
                mdl_header = mdl_header >> 1;
                if (b[7])
                    mdl_header = mdl_header | 8'h40;
                mdl_group[mdl_count] = b;
                mdl_count++;
            end
            if (mdl_count >= shpc_pkg::GROUP_MAX || it.stream_last)
            begin
                words[n].out_byte   = mdl_header & shpc_pkg::LOW7_MASK;
                words[n].run_end    = 1'b0;
                words[n].stream_end = 1'b0;
                n++;
                for (k = 0; k < mdl_count; k++)
                begin
                    words[n].out_byte   = mdl_group[k] & shpc_pkg::LOW7_MASK;
                    words[n].run_end    = 1'b0;
                    words[n].stream_end = 1'b0;
                    n++;
                end
                clear_model_group();
            end
        end
        else if (mdl_header_due)
        begin
            // A header that closes the stream produces nothing.
            mdl_header     = b;
            mdl_count      = 0;
            mdl_header_due = 1'b0;
            if (it.stream_last)
                clear_model_group();
        end
        else
        begin
            if (mdl_count < shpc_pkg::GROUP_MAX)
            begin
                mdl_group[mdl_count] = b;
                mdl_count++;
            end
            if (mdl_count >= shpc_pkg::GROUP_MAX || it.stream_last)
            begin
                for (k = 0; k < mdl_count; k++)
                begin
                    bitpos              = 7 - mdl_count + k;
                    words[n].out_byte   = mdl_group[k];
                    words[n].run_end    = 1'b0;
                    words[n].stream_end = 1'b0;
                    if (mdl_header[bitpos])
                        words[n].out_byte[7] = 1'b1;
                    n++;
                end
                clear_model_group();
            end
        end
        if (n > 0)
        begin
            words[n-1].run_end    = 1'b1;
            words[n-1].stream_end = it.stream_last;
        end
        for (k = 0; k < n; k++)
            expected_words.push_back(words[k]);
    endtask

    // Input driver: a word is held until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
                predict_codec_words(item);
            if (!item_valid || !item_stall)
            begin
                if (pending_bytes.size() > 0 && !take_break())
                begin
                    item       <= pending_bytes.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Output monitor and stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output word %h", result);
                    errors++;
                end
                else
                begin
                    next_word = expected_words.pop_front();
                    if (result.out_byte !== next_word.out_byte)
                    begin
                        $error("out_byte expected %h actual %h",
                               next_word.out_byte, result.out_byte);
                        errors++;
                    end
                    if (result.run_end !== next_word.run_end)
                    begin
                        $error("run_end expected %b actual %b",
                               next_word.run_end, result.run_end);
                        errors++;
                    end
                    if (result.stream_end !== next_word.stream_end)
                    begin
                        $error("stream_end expected %b actual %b",
                               next_word.stream_end, result.stream_end);
                        errors++;
                    end
                end
            end
            result_stall <= take_break();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        shpc_pkg::item_t it;
        it.data_byte   = b;
        it.stream_last = last;
        pending_bytes.push_back(it);
    endtask

    // Waits for all words to drain, then lets the pipeline settle, since
    // some input words leave no trace on the output.
    task automatic wait_quiet();
        while (pending_bytes.size() != 0 || item_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(input logic dir);
        wait_quiet();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mdl_dir = dir;
        clear_model_group();
    endtask

    task automatic push_random_pack(input int count);
        int i;
        for (i = 0; i < count; i++)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 12);
    endtask

    // Mostly well-formed groups, with some stray words mixed in.
    task automatic push_random_unpack(input int count);
        int         i;
        int         k;
        int         n;
        logic [7:0] d;
        i = 0;
        while (i < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 30);
                i++;
            end
            else
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
                n = int'($urandom_range(1, shpc_pkg::GROUP_MAX));
                for (k = 0; k < n; k++)
                begin
                    d = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 99) < 90)
                        d[7] = 1'b0;
                    push_byte(d, (k == n - 1)
                              && (n < shpc_pkg::GROUP_MAX || $urandom_range(0, 1) != 0));
                end
                i += n + 1;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        set_direction(shpc_pkg::DIR_PACK);
        // Full group with mixed top bits, then a short group and a lone byte.
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hfe, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(8'h3c, 1'b1);
        push_byte(8'hc0, 1'b1);
        // This partial group is dropped by the next direction write.
        push_byte(8'h9f, 1'b0);

        set_direction(shpc_pkg::DIR_UNPACK);
        // Full group; data words with bit 7 set pass through unchanged.
        push_byte(8'h7f, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(8'h2a, 1'b0);
        // A header that ends the stream gives no output.
        push_byte(8'h55, 1'b1);
        // Header bit 7 is ignored.
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7f, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_direction(1'($urandom_range(0, 1)));
            calm = (ph == 2);
            if (mdl_dir == shpc_pkg::DIR_PACK)
                push_random_pack(65);
            else
                push_random_unpack(65);
        end

        wait_quiet();
        if (errors == 0 && expected_words.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
